// ===== sv/sal_pkg.sv =====
// ----------------------------------------------------------------------------
// sal_pkg
// Types and codes shared by the shifting array list and its storage cells.
// ----------------------------------------------------------------------------
package sal_pkg;

    localparam int WORD_W  = 32;
    localparam int OP_W    = 3;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 9;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_INSERT     = 3'd4,
        OP_READ       = 3'd5,
        OP_WRITE      = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_LOAD = 2'd1,
        CELL_UP   = 2'd2,
        CELL_DOWN = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t                  op;
        logic signed [WORD_W-1:0]  value;
    } cell_ctrl_t;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  value;
    } cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  read_value;
        logic [COUNT_W-1:0]        item_count;
        status_t                   status;
    } rsp_t;

endpackage

// ===== sv/sal_cell.sv =====
// ----------------------------------------------------------------------------
// sal_cell
// One slot of the list: holds, loads a new word, or takes a neighbor's word.
// ----------------------------------------------------------------------------
module sal_cell (
    input  logic                              clk,
    input  sal_pkg::cell_ctrl_t               ctrl,
    input  logic signed [sal_pkg::WORD_W-1:0] lower,
    input  logic signed [sal_pkg::WORD_W-1:0] upper,
    output logic signed [sal_pkg::WORD_W-1:0] data
);
    import sal_pkg::*;

    logic signed [WORD_W-1:0] data_reg;
    logic signed [WORD_W-1:0] data_next;

    always_comb
    begin
        case (ctrl.op)
            CELL_LOAD: data_next = ctrl.value;
            CELL_UP:   data_next = lower;
            CELL_DOWN: data_next = upper;
            default:   data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== sv/shifting_array_list.sv =====
// ----------------------------------------------------------------------------
// shifting_array_list
// Fixed-capacity ordered list of signed words kept in a row of shifting cells.
// ----------------------------------------------------------------------------
// Each request is one list operation and gives exactly one response with the
// read word, the count after the operation and a status. A request is taken
// every cycle unless the response is held: every cell loads, holds or takes
// its neighbor's word in the same clock, so a front push or pop is as fast as
// any other operation. The response appears in the output register in the
// cycle after the request is taken, and requests keep flowing as long as that
// register is being drained. Words popped or never written are not readable;
// a read or write at or beyond the count reads zero and reports out of range.
module shifting_array_list #(
    parameter int CAPACITY = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_stall,
    input  sal_pkg::cmd_t cmd,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output sal_pkg::rsp_t rsp
);
    import sal_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    rsp_t                     rsp_reg;
    rsp_t                     rsp_next;

    logic                     accept;
    logic [COUNT_W-1:0]       count_ext;
    logic [COUNT_W-1:0]       pos_ext;
    logic [COUNT_W-1:0]       pos_eff;
    logic                     full;
    logic                     empty;
    logic                     do_ins;
    logic                     do_del;
    logic                     do_wr;
    logic signed [WORD_W-1:0] slot_data [CAPACITY];

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign count_ext = COUNT_W'(count_reg);
    assign pos_ext   = COUNT_W'(cmd.position);
    assign full      = (count_ext == COUNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);

    always_comb
    begin
        count_next          = count_reg;
        pos_eff             = pos_ext;
        do_ins              = 1'b0;
        do_del              = 1'b0;
        do_wr               = 1'b0;
        rsp_next.read_value = '0;
        rsp_next.status     = ST_DONE;
        case (op_t'(cmd.operation))
            OP_PUSH_BACK,
            OP_PUSH_FRONT,
            OP_INSERT:
            begin
                if (full)
                begin
                    rsp_next.status = ST_FULL;
                end
                else
                begin
                    do_ins     = 1'b1;
                    count_next = count_reg + CW'(1);
                    if (op_t'(cmd.operation) == OP_PUSH_FRONT)
                        pos_eff = '0;
                    else if (op_t'(cmd.operation) == OP_PUSH_BACK || pos_ext >= count_ext)
                        pos_eff = count_ext;
                end
            end
            OP_POP_BACK,
            OP_POP_FRONT:
            begin
                if (empty)
                begin
                    rsp_next.status = ST_EMPTY;
                end
                else
                begin
                    do_del     = (op_t'(cmd.operation) == OP_POP_FRONT);
                    count_next = count_reg - CW'(1);
                end
            end
            OP_READ:
            begin
                if (pos_ext >= count_ext)
                    rsp_next.status = ST_RANGE;
                else
                    rsp_next.read_value = slot_data[cmd.position[IW-1:0]];
            end
            OP_WRITE:
            begin
                if (pos_ext >= count_ext)
                    rsp_next.status = ST_RANGE;
                else
                    do_wr = 1'b1;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
        rsp_next.item_count = COUNT_W'(count_next);
    end

    // row of cells; each decides from its own index what to do this cycle
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic [COUNT_W-1:0] IDX = COUNT_W'(i);
        cell_ctrl_t               ctrl;
        logic signed [WORD_W-1:0] lower;
        logic signed [WORD_W-1:0] upper;

        always_comb
        begin
            ctrl.value = cmd.value;
            ctrl.op    = CELL_HOLD;
            if (accept)
            begin
                if (do_ins && IDX > pos_eff)
                    ctrl.op = CELL_UP;
                else if ((do_ins || do_wr) && IDX == pos_eff)
                    ctrl.op = CELL_LOAD;
                else if (do_del && i < CAPACITY - 1)
                    ctrl.op = CELL_DOWN;
            end
        end

        if (i == 0)
        begin : g_first
            assign lower = cmd.value;
        end
        else
        begin : g_mid_lo
            assign lower = slot_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign upper = slot_data[i];
        end
        else
        begin : g_mid_hi
            assign upper = slot_data[i+1];
        end

        sal_cell u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .lower (lower),
            .upper (upper),
            .data  (slot_data[i])
        );
    end

    always_comb
    begin
        if (accept)
            rsp_valid_next = 1'b1;
        else if (!rsp_stall)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
                count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_ext <= COUNT_W'(CAPACITY))
        else $error("count above capacity");

    a_count_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count changed without a request");

    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("request gave no response");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == ST_FULL |-> rsp_reg.item_count == COUNT_W'(CAPACITY))
        else $error("full status with room left");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && rsp_reg.status == ST_EMPTY |-> rsp_reg.item_count == '0)
        else $error("empty status with words stored");

endmodule

// ===== test/sal_checker.sv =====
// ----------------------------------------------------------------------------
// sal_checker
// Watches both channels of the shifting array list, keeps its own copy of the
// list, predicts every response and compares it field by field.
// ----------------------------------------------------------------------------
module sal_checker #(
    parameter int CAPACITY = 32
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    input  logic          cmd_stall,
    input  sal_pkg::cmd_t cmd,
    input  logic          rsp_valid,
    input  logic          rsp_stall,
    input  sal_pkg::rsp_t rsp,
    output int            failures,
    output int            outstanding,
    output int            checked,
    output int            flagged
);
    import sal_pkg::*;

    logic signed [WORD_W-1:0] shadow [CAPACITY];
    int unsigned              fill;
    rsp_t                     expected_rsp [$];

    wire cmd_fire = cmd_valid && !cmd_stall;
    wire rsp_fire = rsp_valid && !rsp_stall;

    task automatic report_mismatch(string what, logic [WORD_W-1:0] got,
                                   logic [WORD_W-1:0] want);
        if (failures < 40)
            $display("mismatch after %0d responses: %s got %h expected %h",
                     checked, what, got, want);
        failures++;
    endtask

    // move slots at..fill-1 up one place
    function automatic void make_room(int unsigned at);
        int unsigned i;
        i = fill;
        while (i > at)
        begin
            shadow[i] = shadow[i - 1];
            i--;
        end
    endfunction

    function automatic rsp_t list_apply(cmd_t c);
        rsp_t        r;
        int unsigned at;
        int unsigned i;
        r = '0;
        r.status = ST_DONE;
        case (c.operation)
            OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT:
            begin
                if (fill >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    if (c.operation == OP_PUSH_BACK)
                        at = fill;
                    else if (c.operation == OP_PUSH_FRONT)
                        at = 0;
                    else
                        at = (c.position >= fill) ? fill : c.position;
                    make_room(at);
                    shadow[at] = c.value;
                    fill++;
                end
            end
            OP_POP_BACK:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                    fill--;
            end
            OP_POP_FRONT:
            begin
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    for (i = 0; i + 1 < fill; i++)
                        shadow[i] = shadow[i + 1];
                    fill--;
                end
            end
            OP_READ:
            begin
                if (c.position >= fill)
                    r.status = ST_RANGE;
                else
                    r.read_value = shadow[c.position];
            end
            OP_WRITE:
            begin
                if (c.position >= fill)
                    r.status = ST_RANGE;
                else
                    shadow[c.position] = c.value;
            end
            default:
            begin
            end
        endcase
        r.item_count = COUNT_W'(fill);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            outstanding <= 0;
        else
            outstanding <= outstanding + int'(cmd_fire) - int'(rsp_fire);
    end

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < CAPACITY; k++)
                shadow[k] = '0;
            fill = 0;
            expected_rsp.delete();
            failures = 0;
            checked = 0;
            flagged = 0;
        end
        else
        begin
            if (cmd_fire)
                expected_rsp.push_back(list_apply(cmd));
            if (rsp_fire)
            begin
                if (expected_rsp.size() == 0)
                    report_mismatch("response with no request waiting",
                                    rsp.read_value, '0);
                else
                begin
                    want = expected_rsp.pop_front();
                    if (rsp.read_value !== want.read_value)
                        report_mismatch("read_value", rsp.read_value, want.read_value);
                    if (rsp.item_count !== want.item_count)
                        report_mismatch("item_count", WORD_W'(rsp.item_count),
                                        WORD_W'(want.item_count));
                    if (rsp.status !== want.status)
                        report_mismatch("status", WORD_W'(rsp.status),
                                        WORD_W'(want.status));
                    if (want.status != ST_DONE)
                        flagged++;
                end
                checked++;
            end
        end
    end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives list operations into the shifting array list with random gaps and
// back-pressure; a checker beside the block predicts and compares responses.
// ----------------------------------------------------------------------------
module tb;
    import sal_pkg::*;

    localparam int          CAPACITY   = 32;
    localparam int          ITEMS      = 1800;
    localparam int          PHASE_LEN  = 150;
    localparam int          IDLE_LIMIT = 2000;
    localparam logic [2:0]  OP_IDLE    = 3'd7;

    typedef enum int {
        GROW,
        CHURN,
        SHRINK
    } phase_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    logic steady    = 1'b0;

    int failures;
    int outstanding;
    int checked;
    int flagged;
    int op_seen [8];
    int idle_cycles = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    shifting_array_list #(
        .CAPACITY (CAPACITY)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    sal_checker #(
        .CAPACITY (CAPACITY)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .cmd         (cmd),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .rsp         (rsp),
        .failures    (failures),
        .outstanding (outstanding),
        .checked     (checked),
        .flagged     (flagged)
    );

    always @(posedge clk)
        rsp_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 16);

    always @(posedge clk)
    begin
        if (rst_n && ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // called at a rising edge; returns at the edge where the request is taken
    task automatic issue(logic [2:0] op, logic [7:0] pos, logic [31:0] val);
        while (!steady && $urandom_range(0, 99) < 16)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid      <= 1'b1;
        cmd.operation  <= op;
        cmd.position   <= pos;
        cmd.value      <= val;
        op_seen[op]++;
        do
            @(posedge clk);
        while (!(cmd_valid && !cmd_stall));
    endtask

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 24))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic issue_random(phase_t mode);
        int         grow;
        int         shrink;
        int         roll;
        logic [2:0] op;
        logic [7:0] pos;
        grow   = (mode == GROW) ? 65 : (mode == SHRINK) ? 20 : 40;
        shrink = (mode == SHRINK) ? 65 : (mode == GROW) ? 15 : 35;
        roll   = $urandom_range(0, 99);
        if (roll < grow)
        begin
            case ($urandom_range(0, 2))
                0:       op = OP_PUSH_BACK;
                1:       op = OP_PUSH_FRONT;
                default: op = OP_INSERT;
            endcase
        end
        else if (roll < grow + shrink)
            op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        else if (roll < 98)
            op = $urandom_range(0, 1) ? OP_READ : OP_WRITE;
        else
            op = OP_IDLE;
        // mostly near the stored range, sometimes anywhere in the byte
        pos = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                          : 8'($urandom_range(0, CAPACITY + 4));
        issue(op, pos, pick_word());
    endtask

    initial
    begin
        phase_t mode;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list corner cases
        issue(OP_POP_BACK,   8'd0,   32'h0);
        issue(OP_POP_FRONT,  8'd0,   32'h0);
        issue(OP_READ,       8'd0,   32'h0);
        issue(OP_WRITE,      8'd0,   32'h5);
        issue(OP_IDLE,       8'd0,   32'h0);
        // build a short list from both ends and the middle
        issue(OP_PUSH_BACK,  8'd0,   32'h7FFF_FFFF);
        issue(OP_PUSH_FRONT, 8'd0,   32'h8000_0000);
        issue(OP_INSERT,     8'd255, 32'hFFFF_FFFF);
        issue(OP_INSERT,     8'd0,   32'h0000_0000);
        issue(OP_INSERT,     8'd1,   32'h1234_5678);
        for (int p = 0; p <= 5; p++)
            issue(OP_READ, 8'(p), 32'h0);
        issue(OP_WRITE,      8'd2,   32'hA5A5_A5A5);
        issue(OP_READ,       8'd2,   32'h0);
        issue(OP_WRITE,      8'd255, 32'h5A5A_5A5A);
        issue(OP_READ,       8'd255, 32'h0);
        issue(OP_POP_FRONT,  8'd0,   32'h0);
        issue(OP_POP_BACK,   8'd0,   32'h0);
        issue(OP_READ,       8'd0,   32'h0);
        issue(OP_IDLE,       8'd255, 32'hFFFF_FFFF);
        wait_drained();

        for (int ph = 0; ph < ITEMS / PHASE_LEN; ph++)
        begin
            case (ph % 4)
                0:       mode = GROW;
                2:       mode = SHRINK;
                default: mode = CHURN;
            endcase
            // phases 4 and 5 run with no gaps and no back-pressure
            steady <= (ph == 4 || ph == 5);
            for (int n = 0; n < PHASE_LEN; n++)
                issue_random(mode);
            wait_drained();
        end

        steady <= 1'b0;
        wait_drained();
        repeat (8) @(posedge clk);

        $display("sent %0d requests: %0d push back, %0d push front, %0d pop back, %0d pop front,",
                 checked, op_seen[OP_PUSH_BACK], op_seen[OP_PUSH_FRONT],
                 op_seen[OP_POP_BACK], op_seen[OP_POP_FRONT]);
        $display("  %0d insert, %0d read, %0d write, %0d no-op; %0d rejected as full/empty/range",
                 op_seen[OP_INSERT], op_seen[OP_READ], op_seen[OP_WRITE],
                 op_seen[OP_IDLE], flagged);
        if (failures == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
